@@ hdl/hsv_color_key_centroid_core_defines.svh @@
// ---------------------------------------------------------------------------
// HSV color key centroid assertion macros
// Shared concurrent assertion forms for the checker of the keying core.
// ---------------------------------------------------------------------------
`ifndef HSV_COLOR_KEY_CENTROID_CORE_DEFINES_SVH
`define HSV_COLOR_KEY_CENTROID_CORE_DEFINES_SVH

// same-cycle implication
`define HCK_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("hck: check failed");

// next-cycle implication
`define HCK_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("hck: check failed");

`endif

@@ hdl/hck_pkg.sv @@
// ---------------------------------------------------------------------------
// HSV color key centroid package
// Sizes, register indexes, sequencer states and shared types.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package hck_pkg;

	localparam int MAX_COLS         = 1024;
	localparam int MAX_ROWS         = 1024;
	localparam int WEIGHT_FRAC_BITS = 8;

	localparam int HUE_W      = 9;
	localparam int PIX_HUE_W  = 8;
	localparam int SAT_W      = 8;
	localparam int TOL_W      = 9;
	localparam int WGT_IN_W   = 9;
	localparam int POS_W      = 10;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 9;

	localparam int SUM_W     = 31;
	localparam int CNT_W     = 21;
	localparam int DIV_STEPS = SUM_W;
	localparam int STEP_W    = $clog2(DIV_STEPS);

	localparam int WGT_W  = (WEIGHT_FRAC_BITS + 1 > WGT_IN_W) ? WEIGHT_FRAC_BITS + 1 : WGT_IN_W;
	localparam int PROD_W = WGT_W + POS_W;
	localparam int RND_W  = PROD_W - WEIGHT_FRAC_BITS;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_HUE_CENTER    = 3'd0,
		REG_HUE_TOLERANCE = 3'd1,
		REG_SAT_CENTER    = 3'd2,
		REG_SAT_TOLERANCE = 3'd3,
		REG_BLEND_WEIGHT  = 3'd4
	} hck_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_XDIV_START,
		ST_XDIV_WAIT,
		ST_XBLEND_WAIT,
		ST_YDIV_START,
		ST_YDIV_WAIT,
		ST_YBLEND_WAIT,
		ST_FINISH
	} hck_state_t;

	typedef struct packed {
		logic keyed;
		logic empty;
	} hck_acc_sts_t;

endpackage

@@ hdl/hck_key.sv @@
// ---------------------------------------------------------------------------
// HSV color key test and accumulator
// Keys a pixel on hue and saturation distance and sums keyed coordinates.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module hck_key import hck_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 accept,
	input  logic                 clear,
	input  logic [PIX_HUE_W-1:0] pixel_hue,
	input  logic [SAT_W-1:0]     pixel_sat,
	input  logic [POS_W-1:0]     col_pos,
	input  logic [POS_W-1:0]     row_pos,
	input  logic [HUE_W-1:0]     hue_center,
	input  logic [TOL_W-1:0]     hue_tolerance,
	input  logic [SAT_W-1:0]     sat_center,
	input  logic [TOL_W-1:0]     sat_tolerance,
	output hck_acc_sts_t         sts,
	output logic [SUM_W-1:0]     sum_cols,
	output logic [SUM_W-1:0]     sum_rows,
	output logic [CNT_W-1:0]     hit_count
);

	localparam logic [11:0] COL_LAST = 12'(MAX_COLS - 1);
	localparam logic [11:0] ROW_LAST = 12'(MAX_ROWS - 1);

	logic [SUM_W-1:0] sum_cols_q;
	logic [SUM_W-1:0] sum_rows_q;
	logic [CNT_W-1:0] hit_count_q;
	logic [HUE_W-1:0] hue2;
	logic [HUE_W-1:0] hue_dist;
	logic [SAT_W-1:0] sat_dist;
	logic [POS_W-1:0] col_clip;
	logic [POS_W-1:0] row_clip;
	logic             keyed;
	logic             add;
	logic [CNT_W-1:0] cnt_nxt;

	always_comb begin
		hue2     = {pixel_hue, 1'b0};
		hue_dist = (hue_center > hue2) ? hue_center - hue2 : hue2 - hue_center;
		sat_dist = (sat_center > pixel_sat) ? sat_center - pixel_sat : pixel_sat - sat_center;
		keyed    = (hue_dist < hue_tolerance) && ({1'b0, sat_dist} < sat_tolerance);
		col_clip = ({2'b00, col_pos} > COL_LAST) ? COL_LAST[POS_W-1:0] : col_pos;
		row_clip = ({2'b00, row_pos} > ROW_LAST) ? ROW_LAST[POS_W-1:0] : row_pos;
		add      = keyed && !(&hit_count_q);
		cnt_nxt  = hit_count_q + CNT_W'(add);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_cols_q  <= '0;
			sum_rows_q  <= '0;
			hit_count_q <= '0;
		end else if (clear) begin
			sum_cols_q  <= '0;
			sum_rows_q  <= '0;
			hit_count_q <= '0;
		end else if (accept && add) begin
			sum_cols_q  <= sum_cols_q + SUM_W'(col_clip);
			sum_rows_q  <= sum_rows_q + SUM_W'(row_clip);
			hit_count_q <= cnt_nxt;
		end
	end

	assign sts.keyed = keyed;
	assign sts.empty = (cnt_nxt == '0);
	assign sum_cols  = sum_cols_q;
	assign sum_rows  = sum_rows_q;
	assign hit_count = hit_count_q;

endmodule

@@ hdl/hck_div.sv @@
// ---------------------------------------------------------------------------
// HSV color key centroid divider
// Restoring divider, one quotient bit per cycle, shared by both axes.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module hck_div import hck_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [SUM_W-1:0] dividend,
	input  logic [CNT_W-1:0] divisor,
	output logic             done,
	output logic [SUM_W-1:0] quotient
);

	logic [SUM_W-1:0]  dvd_q;
	logic [CNT_W:0]    rem_q;
	logic [CNT_W-1:0]  dsr_q;
	logic [STEP_W-1:0] cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [CNT_W:0]    rem_sh;
	logic [CNT_W:0]    rem_dif;
	logic              fits;

	always_comb begin
		rem_sh  = {rem_q[CNT_W-1:0], dvd_q[SUM_W-1]};
		fits    = rem_sh >= {1'b0, dsr_q};
		rem_dif = rem_sh - {1'b0, dsr_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= !start && busy_q && (cnt_q == '0);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= STEP_W'(DIV_STEPS - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0)
					busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dsr_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[SUM_W-2:0], fits};
			rem_q <= fits ? rem_dif : rem_sh;
		end
	end

	assign done     = done_q;
	assign quotient = dvd_q;

endmodule

@@ hdl/hck_blend.sv @@
// ---------------------------------------------------------------------------
// HSV color key centroid blend unit
// Weights old center and mean with one shared multiplier.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module hck_blend import hck_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [POS_W-1:0]    old_pos,
	input  logic [POS_W-1:0]    mean_pos,
	input  logic [WGT_IN_W-1:0] blend_weight,
	output logic                done,
	output logic [POS_W-1:0]    result
);

	localparam logic [WGT_W-1:0] ONE = WGT_W'(1) << WEIGHT_FRAC_BITS;
	localparam logic [WEIGHT_FRAC_BITS-1:0] HALF = {1'b1, {(WEIGHT_FRAC_BITS-1){1'b0}}};
	localparam logic [RND_W:0] POS_MAX = {{(RND_W+1-POS_W){1'b0}}, {POS_W{1'b1}}};

	function automatic logic [RND_W-1:0] round_term(input logic [PROD_W-1:0] p);
		logic [RND_W-1:0]            q;
		logic [WEIGHT_FRAC_BITS-1:0] r;
		logic                        up;
		q  = p[PROD_W-1:WEIGHT_FRAC_BITS];
		r  = p[WEIGHT_FRAC_BITS-1:0];
		up = (r > HALF) || ((r == HALF) && q[0]);
		return q + RND_W'(up);
	endfunction

	logic [WGT_W-1:0]  a_ext;
	logic [WGT_W-1:0]  a_sat;
	logic [WGT_W-1:0]  a_q;
	logic [POS_W-1:0]  old_q;
	logic [POS_W-1:0]  mean_q;
	logic [1:0]        phase_q;
	logic              busy_q;
	logic              done_q;
	logic [PROD_W-1:0] prod_q;
	logic [RND_W-1:0]  acc_q;
	logic [POS_W-1:0]  res_q;
	logic [WGT_W-1:0]  mul_a;
	logic [POS_W-1:0]  mul_b;
	logic [PROD_W-1:0] prod;
	logic [RND_W:0]    total;

	always_comb begin
		a_ext = WGT_W'(blend_weight);
		a_sat = (a_ext > ONE) ? ONE : a_ext;
		mul_a = (phase_q == 2'd0) ? ONE - a_q : a_q;
		mul_b = (phase_q == 2'd0) ? old_q : mean_q;
		prod  = PROD_W'(mul_a) * PROD_W'(mul_b);
		total = {1'b0, acc_q} + {1'b0, round_term(prod_q)};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
			phase_q <= 2'd0;
		end else begin
			done_q <= !start && busy_q && phase_q[1];
			if (start) begin
				busy_q  <= 1'b1;
				phase_q <= 2'd0;
			end else if (busy_q) begin
				case (phase_q)
					2'd0: phase_q <= 2'd1;
					2'd1: phase_q <= 2'd2;
					default: begin
						phase_q <= 2'd0;
						busy_q  <= 1'b0;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q    <= a_sat;
			old_q  <= old_pos;
			mean_q <= mean_pos;
		end
		if (busy_q) begin
			prod_q <= prod;
			if (phase_q == 2'd1)
				acc_q <= round_term(prod_q);
			if (phase_q == 2'd2)
				res_q <= (total > POS_MAX) ? POS_MAX[POS_W-1:0] : total[POS_W-1:0];
		end
	end

	assign done   = done_q;
	assign result = res_q;

endmodule

@@ hdl/hsv_color_key_centroid_core.sv @@
// A pixel word with no frame end, or a frame end on a frame with no keyed
// pixel, is taken without holding the input and its result shows the
// next cycle, so such words flow at one per cycle while the result side
// keeps up. A frame end on a frame with keyed pixels holds the input, and
// holds it longer while the result side stalls the last word: the mean
// column and the mean row each go through the one shared restoring
// divider, one quotient bit per cycle, and then through the blend
// multiplier before the result is shown.
// ---------------------------------------------------------------------------
// HSV color key centroid core
// Keys HSV pixels against a configured color and tracks the keyed centroid.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module hsv_color_key_centroid_core import hck_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  pix_valid,
	output logic                  pix_stall,
	input  logic [PIX_HUE_W-1:0]  pixel_hue,
	input  logic [SAT_W-1:0]      pixel_sat,
	input  logic [POS_W-1:0]      col_pos,
	input  logic [POS_W-1:0]      row_pos,
	input  logic                  frame_end,
	output logic                  res_valid,
	input  logic                  res_stall,
	output logic                  key_mask,
	output logic [POS_W-1:0]      track_x,
	output logic [POS_W-1:0]      track_y,
	output logic                  track_updated
);

	hck_state_t state_q, state_d;

	logic [HUE_W-1:0]    hue_center_q;
	logic [TOL_W-1:0]    hue_tolerance_q;
	logic [SAT_W-1:0]    sat_center_q;
	logic [TOL_W-1:0]    sat_tolerance_q;
	logic [WGT_IN_W-1:0] blend_weight_q;

	logic [POS_W-1:0] smooth_x_q;
	logic [POS_W-1:0] smooth_y_q;
	logic             key_q;

	logic             res_valid_q;
	logic             key_mask_q;
	logic [POS_W-1:0] track_x_q;
	logic [POS_W-1:0] track_y_q;
	logic             track_updated_q;

	hck_acc_sts_t     acc_sts;
	logic [SUM_W-1:0] sum_cols;
	logic [SUM_W-1:0] sum_rows;
	logic [CNT_W-1:0] hit_count;

	logic             pix_accept;
	logic             out_free;
	logic             go_track;
	logic             div_start;
	logic             div_done;
	logic [SUM_W-1:0] div_dividend;
	logic [SUM_W-1:0] quotient;
	logic             blend_start;
	logic             blend_done;
	logic [POS_W-1:0] blend_old;
	logic [POS_W-1:0] blend_res;
	logic             set_x;
	logic             set_y;
	logic             finish;

	assign out_free   = !res_valid_q || !res_stall;
	assign pix_stall  = !((state_q == ST_IDLE) && out_free);
	assign pix_accept = pix_valid && !pix_stall;
	assign go_track   = pix_accept && frame_end && !acc_sts.empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hue_center_q    <= '0;
			hue_tolerance_q <= '0;
			sat_center_q    <= '0;
			sat_tolerance_q <= '0;
			blend_weight_q  <= '0;
		end else if (cfg_we) begin
			unique case (hck_reg_t'(cfg_index))
				REG_HUE_CENTER:    hue_center_q    <= cfg_data[HUE_W-1:0];
				REG_HUE_TOLERANCE: hue_tolerance_q <= cfg_data[TOL_W-1:0];
				REG_SAT_CENTER:    sat_center_q    <= cfg_data[SAT_W-1:0];
				REG_SAT_TOLERANCE: sat_tolerance_q <= cfg_data[TOL_W-1:0];
				REG_BLEND_WEIGHT:  blend_weight_q  <= cfg_data[WGT_IN_W-1:0];
				default: ;
			endcase
		end
	end

	hck_key u_key (
		.clk           (clk),
		.arst_n        (arst_n),
		.accept        (pix_accept),
		.clear         (finish),
		.pixel_hue     (pixel_hue),
		.pixel_sat     (pixel_sat),
		.col_pos       (col_pos),
		.row_pos       (row_pos),
		.hue_center    (hue_center_q),
		.hue_tolerance (hue_tolerance_q),
		.sat_center    (sat_center_q),
		.sat_tolerance (sat_tolerance_q),
		.sts           (acc_sts),
		.sum_cols      (sum_cols),
		.sum_rows      (sum_rows),
		.hit_count     (hit_count)
	);

	assign div_dividend = (state_q == ST_XDIV_START) ? sum_cols : sum_rows;

	hck_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (hit_count),
		.done     (div_done),
		.quotient (quotient)
	);

	assign blend_old = (state_q == ST_XDIV_WAIT) ? smooth_x_q : smooth_y_q;

	hck_blend u_blend (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (blend_start),
		.old_pos      (blend_old),
		.mean_pos     (quotient[POS_W-1:0]),
		.blend_weight (blend_weight_q),
		.done         (blend_done),
		.result       (blend_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d     = state_q;
		div_start   = 1'b0;
		blend_start = 1'b0;
		set_x       = 1'b0;
		set_y       = 1'b0;
		finish      = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (go_track)
					state_d = ST_XDIV_START;
			end
			ST_XDIV_START: begin
				div_start = 1'b1;
				state_d   = ST_XDIV_WAIT;
			end
			ST_XDIV_WAIT: begin
				if (div_done) begin
					blend_start = 1'b1;
					state_d     = ST_XBLEND_WAIT;
				end
			end
			ST_XBLEND_WAIT: begin
				if (blend_done) begin
					set_x   = 1'b1;
					state_d = ST_YDIV_START;
				end
			end
			ST_YDIV_START: begin
				div_start = 1'b1;
				state_d   = ST_YDIV_WAIT;
			end
			ST_YDIV_WAIT: begin
				if (div_done) begin
					blend_start = 1'b1;
					state_d     = ST_YBLEND_WAIT;
				end
			end
			ST_YBLEND_WAIT: begin
				if (blend_done) begin
					set_y   = 1'b1;
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (out_free) begin
					finish  = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			smooth_x_q <= '0;
			smooth_y_q <= '0;
		end else begin
			if (set_x)
				smooth_x_q <= blend_res;
			if (set_y)
				smooth_y_q <= blend_res;
		end
	end

	always_ff @(posedge clk) begin
		if (pix_accept)
			key_q <= acc_sts.keyed;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			res_valid_q <= 1'b0;
		else if ((pix_accept && !go_track) || finish)
			res_valid_q <= 1'b1;
		else if (!res_stall)
			res_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (pix_accept && !go_track) begin
			key_mask_q      <= acc_sts.keyed;
			track_x_q       <= smooth_x_q;
			track_y_q       <= smooth_y_q;
			track_updated_q <= 1'b0;
		end else if (finish) begin
			key_mask_q      <= key_q;
			track_x_q       <= smooth_x_q;
			track_y_q       <= smooth_y_q;
			track_updated_q <= 1'b1;
		end
	end

	assign res_valid     = res_valid_q;
	assign key_mask      = key_mask_q;
	assign track_x       = track_x_q;
	assign track_y       = track_y_q;
	assign track_updated = track_updated_q;

endmodule

@@ hdl/hck_checker.sv @@
// ---------------------------------------------------------------------------
// HSV color key centroid checker
// Port-level timing checks on the keying core, bound to the top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "hsv_color_key_centroid_core_defines.svh"

module hck_checker import hck_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             pix_valid,
	input logic             pix_stall,
	input logic             frame_end,
	input logic             res_valid,
	input logic             res_stall,
	input logic             key_mask,
	input logic [POS_W-1:0] track_x,
	input logic [POS_W-1:0] track_y,
	input logic             track_updated
);

	// hold a stalled result word
	`HCK_ASSERT_NEXT(a_res_hold, clk, arst_n, res_valid && res_stall, res_valid && $stable(key_mask) && $stable(track_x) && $stable(track_y) && $stable(track_updated))

	// plain pixel gives its word next cycle
	`HCK_ASSERT_NEXT(a_pix_next, clk, arst_n, pix_valid && !pix_stall && !frame_end, res_valid && !track_updated)

	// frame end either reports at once or holds the input
	`HCK_ASSERT_NEXT(a_frame_end, clk, arst_n, pix_valid && !pix_stall && frame_end, pix_stall || (res_valid && !track_updated))

	// an updated center appears only after the input was held
	`HCK_ASSERT_IMPL(a_update_held, clk, arst_n, $rose(res_valid) && track_updated, $past(pix_stall))

endmodule

bind hsv_color_key_centroid_core hck_checker u_hck_checker (.*);

@@ tb/hsv_key_track_checker.sv @@
// ---------------------------------------------------------------------------
// HSV color key centroid checker
// Follows register writes and accepted pixel words, predicts the key mask
// and tracked center of each word, and compares every accepted result word
// field by field, in order, against the oldest prediction.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module hsv_key_track_checker import hck_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  pix_valid,
	input  logic                  pix_stall,
	input  logic [PIX_HUE_W-1:0]  pixel_hue,
	input  logic [SAT_W-1:0]      pixel_sat,
	input  logic [POS_W-1:0]      col_pos,
	input  logic [POS_W-1:0]      row_pos,
	input  logic                  frame_end,
	input  logic                  res_valid,
	input  logic                  res_stall,
	input  logic                  key_mask,
	input  logic [POS_W-1:0]      track_x,
	input  logic [POS_W-1:0]      track_y,
	input  logic                  track_updated,
	output int                    pending_words,
	output int                    mismatch_count
);

	localparam int WEIGHT_ONE = 1 << WEIGHT_FRAC_BITS;
	localparam int COUNT_MAX  = (1 << CNT_W) - 1;
	localparam int POS_MAX    = (1 << POS_W) - 1;

	typedef struct packed {
		logic             key;
		logic [POS_W-1:0] x;
		logic [POS_W-1:0] y;
		logic             updated;
	} key_track_t;

	logic [HUE_W-1:0]    hue_center;
	logic [TOL_W-1:0]    hue_tol;
	logic [SAT_W-1:0]    sat_center;
	logic [TOL_W-1:0]    sat_tol;
	logic [WGT_IN_W-1:0] blend_wgt;

	logic [SUM_W-1:0] sum_cols;
	logic [SUM_W-1:0] sum_rows;
	logic [CNT_W-1:0] hit_count;
	logic [POS_W-1:0] smooth_x;
	logic [POS_W-1:0] smooth_y;

	key_track_t key_track_q[$];
	key_track_t want;

	// round to nearest, ties to even, dropping the weight fraction
	function automatic int unsigned round_weight(int unsigned n);
		int unsigned q;
		int unsigned r;
		q = n >> WEIGHT_FRAC_BITS;
		r = n & (WEIGHT_ONE - 1);
		if (r > WEIGHT_ONE / 2 || (r == WEIGHT_ONE / 2 && (q & 1) != 0))
			q++;
		return q;
	endfunction

	function automatic logic [POS_W-1:0] blend_pos(logic [POS_W-1:0] prev,
			int unsigned mean, int unsigned a);
		int unsigned v;
		v = round_weight((WEIGHT_ONE - a) * prev) + round_weight(a * mean);
		return (v > POS_MAX) ? POS_MAX[POS_W-1:0] : v[POS_W-1:0];
	endfunction

	function automatic key_track_t key_and_track(logic [PIX_HUE_W-1:0] hue,
			logic [SAT_W-1:0] sat, logic [POS_W-1:0] x, logic [POS_W-1:0] y,
			logic last);
		key_track_t w;
		int unsigned hue_deg;
		int unsigned dh;
		int unsigned ds;
		int unsigned a;
		hue_deg = 2 * int'(hue);
		dh = (hue_center > hue_deg) ? hue_center - hue_deg : hue_deg - hue_center;
		ds = (sat_center > sat) ? sat_center - sat : sat - sat_center;
		if (x > MAX_COLS - 1)
			x = POS_W'(MAX_COLS - 1);
		if (y > MAX_ROWS - 1)
			y = POS_W'(MAX_ROWS - 1);
		w.key = (dh < hue_tol) && (ds < sat_tol);
		w.updated = 1'b0;
		if (w.key && hit_count < COUNT_MAX) begin
			sum_cols += x;
			sum_rows += y;
			hit_count++;
		end
		if (last) begin
			if (hit_count != 0) begin
				a = (blend_wgt > WEIGHT_ONE) ? WEIGHT_ONE : blend_wgt;
				smooth_x = blend_pos(smooth_x, int'(sum_cols) / int'(hit_count), a);
				smooth_y = blend_pos(smooth_y, int'(sum_rows) / int'(hit_count), a);
				w.updated = 1'b1;
			end
			sum_cols = '0;
			sum_rows = '0;
			hit_count = '0;
		end
		w.x = smooth_x;
		w.y = smooth_y;
		return w;
	endfunction

	task automatic check_field(string field, int unsigned want_v, int unsigned got_v);
		if (want_v != got_v) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want_v, got_v);
			mismatch_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hue_center = '0;
			hue_tol = '0;
			sat_center = '0;
			sat_tol = '0;
			blend_wgt = '0;
			sum_cols = '0;
			sum_rows = '0;
			hit_count = '0;
			smooth_x = '0;
			smooth_y = '0;
			key_track_q.delete();
			pending_words <= 0;
		end else begin
			if (cfg_we) begin
				case (hck_reg_t'(cfg_index))
					REG_HUE_CENTER:    hue_center = cfg_data;
					REG_HUE_TOLERANCE: hue_tol = cfg_data;
					REG_SAT_CENTER:    sat_center = cfg_data[SAT_W-1:0];
					REG_SAT_TOLERANCE: sat_tol = cfg_data;
					REG_BLEND_WEIGHT:  blend_wgt = cfg_data;
					default: ;
				endcase
			end
			if (pix_valid && !pix_stall)
				key_track_q.push_back(key_and_track(pixel_hue, pixel_sat, col_pos, row_pos,
					frame_end));
			if (res_valid && !res_stall) begin
				if (key_track_q.size() == 0) begin
					$display("%0t: unexpected word, expected none, got mask %0d x %0d y %0d upd %0d",
						$time, key_mask, track_x, track_y, track_updated);
					mismatch_count++;
				end else begin
					want = key_track_q.pop_front();
					check_field("key_mask", want.key, key_mask);
					check_field("track_x", want.x, track_x);
					check_field("track_y", want.y, track_y);
					check_field("track_updated", want.updated, track_updated);
				end
			end
			pending_words <= key_track_q.size();
		end
	end

endmodule

@@ tb/tb.sv @@
// ---------------------------------------------------------------------------
// HSV color key centroid testbench
// Drives directed and random pixel frames through the keying core under
// several register settings, with random idling on both sides and a long
// result-side hold-off; the checker predicts and compares every word.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
	import hck_pkg::*;

	typedef struct packed {
		logic [HUE_W-1:0]    hue_c;
		logic [TOL_W-1:0]    hue_t;
		logic [SAT_W-1:0]    sat_c;
		logic [TOL_W-1:0]    sat_t;
		logic [WGT_IN_W-1:0] wgt;
	} cfg_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  pix_valid = 1'b0;
	logic                  pix_stall;
	logic [PIX_HUE_W-1:0]  pixel_hue = '0;
	logic [SAT_W-1:0]      pixel_sat = '0;
	logic [POS_W-1:0]      col_pos = '0;
	logic [POS_W-1:0]      row_pos = '0;
	logic                  frame_end = 1'b0;
	logic                  res_valid;
	logic                  res_stall = 1'b0;
	logic                  key_mask;
	logic [POS_W-1:0]      track_x;
	logic [POS_W-1:0]      track_y;
	logic                  track_updated;
	int                    pending_words;
	int                    mismatch_count;

	bit tx_gaps = 1'b1;
	bit rx_gaps = 1'b1;
	bit hold_off_go = 1'b0;
	int sent_words;

	hsv_color_key_centroid_core u_top (.*);

	hsv_key_track_checker u_chk (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#2_000_000;
		$display("FAILURE");
		$finish;
	end

	// result side: random stall, or a long hold-off on request
	initial begin
		forever begin
			@(posedge clk);
			if (hold_off_go) begin
				res_stall <= 1'b1;
				repeat (300) @(posedge clk);
				hold_off_go = 1'b0;
			end else begin
				res_stall <= rx_gaps && ($urandom_range(0, 99) < 28);
			end
		end
	end

	task automatic send_word(input logic [PIX_HUE_W-1:0] h, input logic [SAT_W-1:0] s,
			input logic [POS_W-1:0] x, input logic [POS_W-1:0] y, input logic last);
		if (tx_gaps && $urandom_range(0, 99) < 24) begin
			pix_valid <= 1'b0;
			repeat ($urandom_range(1, 2)) @(posedge clk);
		end
		pix_valid <= 1'b1;
		pixel_hue <= h;
		pixel_sat <= s;
		col_pos <= x;
		row_pos <= y;
		frame_end <= last;
		do @(posedge clk); while (pix_stall);
		sent_words++;
	endtask

	task automatic drain();
		pix_valid <= 1'b0;
		do @(posedge clk); while (pending_words != 0);
	endtask

	task automatic write_regs(input cfg_t c);
		cfg_we <= 1'b1;
		cfg_index <= REG_HUE_CENTER;
		cfg_data <= c.hue_c;
		@(posedge clk);
		cfg_index <= REG_HUE_TOLERANCE;
		cfg_data <= c.hue_t;
		@(posedge clk);
		cfg_index <= REG_SAT_CENTER;
		cfg_data <= CFG_DATA_W'(c.sat_c);
		@(posedge clk);
		cfg_index <= REG_SAT_TOLERANCE;
		cfg_data <= c.sat_t;
		@(posedge clk);
		cfg_index <= REG_BLEND_WEIGHT;
		cfg_data <= c.wgt;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic int pick_value(int e0, int e1, int e2, int lo, int hi);
		case ($urandom_range(0, 9))
			0: return e0;
			1: return e1;
			2: return e2;
			default: return $urandom_range(lo, hi);
		endcase
	endfunction

	function automatic cfg_t random_cfg();
		cfg_t c;
		c.hue_c = HUE_W'(pick_value(0, 359, 511, 0, 359));
		c.hue_t = TOL_W'(pick_value(0, 360, 511, 4, 120));
		c.sat_c = SAT_W'(pick_value(0, 255, 255, 0, 255));
		c.sat_t = TOL_W'(pick_value(0, 256, 511, 4, 80));
		c.wgt = WGT_IN_W'(pick_value(0, 256, 511, 1, 255));
		return c;
	endfunction

	function automatic logic [POS_W-1:0] random_pos();
		if ($urandom_range(0, 7) == 0)
			return $urandom_range(0, 1) ? 10'd1023 : 10'd0;
		return POS_W'($urandom_range(0, 1023));
	endfunction

	// pixels cluster around the key center so that frames mix hits and misses
	task automatic random_frame(input cfg_t c);
		int len;
		int span_h;
		int span_s;
		int h;
		int s;
		len = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 60) : $urandom_range(1, 12);
		span_h = int'(c.hue_t) / 2 + 2;
		span_s = int'(c.sat_t) + 2;
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(0, 99) < 65) begin
				h = int'(c.hue_c) / 2 + int'($urandom_range(0, 2 * span_h)) - span_h;
				s = int'(c.sat_c) + int'($urandom_range(0, 2 * span_s)) - span_s;
			end else begin
				h = $urandom_range(0, 255);
				s = $urandom_range(0, 255);
			end
			h = (h < 0) ? 0 : (h > 255) ? 255 : h;
			s = (s < 0) ? 0 : (s > 255) ? 255 : s;
			send_word(h[7:0], s[7:0], random_pos(), random_pos(), i == len - 1);
		end
	endtask

	initial begin
		cfg_t c;
		arst_n = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// registers at reset: nothing keys, empty frame
		send_word(60, 200, 5, 7, 0);
		send_word(60, 200, 5, 7, 1);
		drain();

		// weight above one saturates, center jumps to the mean
		c = '{hue_c: 120, hue_t: 40, sat_c: 200, sat_t: 60, wgt: 511};
		write_regs(c);
		send_word(60, 200, 1023, 1023, 0);
		send_word(255, 255, 0, 0, 0);
		send_word(0, 0, 512, 341, 0);
		send_word(40, 200, 0, 0, 0);
		send_word(41, 200, 1023, 1023, 0);
		send_word(79, 200, 1023, 1023, 0);
		send_word(80, 200, 682, 0, 0);
		send_word(60, 140, 0, 1023, 0);
		send_word(60, 141, 1023, 1023, 0);
		send_word(60, 255, 1023, 1023, 1);
		drain();

		// half weight: blended center overflows, then a frame near the origin and an empty frame
		c.wgt = 128;
		write_regs(c);
		send_word(60, 200, 1023, 1023, 1);
		send_word(60, 200, 0, 0, 0);
		send_word(60, 200, 0, 1, 1);
		send_word(0, 0, 3, 3, 1);
		drain();

		// widest tolerances, zero weight
		c = '{hue_c: 0, hue_t: 511, sat_c: 255, sat_t: 256, wgt: 0};
		write_regs(c);
		send_word(255, 0, 1023, 0, 0);
		send_word(0, 255, 0, 1023, 1);
		send_word(179, 128, 341, 682, 1);

		for (int p = 0; p < 6; p++) begin
			drain();
			c = random_cfg();
			write_regs(c);
			tx_gaps = (p != 1);
			rx_gaps = (p != 1);
			if (p == 3)
				hold_off_go = 1'b1;
			sent_words = 0;
			while (sent_words < 63)
				random_frame(c);
		end

		drain();
		repeat (100) @(posedge clk);
		@(negedge clk);
		if (mismatch_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
